// ----- rtl/core/sv39ptw_pkg.sv -----
package sv39ptw_pkg;

  localparam int unsigned TABLE_PAGES_DEF   = 16;
  localparam int unsigned VA_LIMIT_BITS_DEF = 38;
  localparam int unsigned ENTRIES_PER_PAGE  = 512;

  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned VA_W     = OFFSET_W + 3 * SLOT_W;
  localparam int unsigned PPN_W    = 44;
  localparam int unsigned PTE_W    = 54;
  localparam int unsigned PA_W     = 56;
  localparam int unsigned FLAGS_W  = 10;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned CFG_W    = 44;

  localparam int unsigned FLAG_V_BIT = 0;
  localparam int unsigned FLAG_U_BIT = 4;

  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  localparam logic CFG_ROOT_TABLE_PAGE = 1'b0;
  localparam logic CFG_STORE_BASE_PPN  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_NOT_MAPPED = 3'd2,
    ST_NOT_USER   = 3'd3,
    ST_OUTSIDE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    IDLE,
    WALK2,
    WALK1,
    LEAF
  } walk_state_e;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  entry_index;
    logic [PTE_W-1:0]  entry_value;
    logic [63:0]       vaddr;
    logic              require_user;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [PA_W-1:0]    phys_addr;
    logic [FLAGS_W-1:0] leaf_flags;
  } out_item_t;

endpackage

// ----- rtl/core/sv39_page_table_walker.sv -----
// Sv39 page-table walker over a local store of table pages.
// Input channel (in_valid_i, in_stall_o, in_item_i): each transaction either
// writes one table entry or asks for the translation of a virtual address.
// Output channel (out_valid_o, out_stall_i, out_item_o): exactly one result
// transaction per input transaction, in order.
// Configuration: cfg_we_i with cfg_idx_i selects the root table page or the
// store base PPN; write it only while no transaction is in flight.
//
// An entry write, an address over the limit or a root page outside the store
// is answered in the cycle of acceptance; the result shows in the next cycle.
// A full walk issues one read of the single-port table memory per level: the
// three dependent reads are issued in IDLE, WALK2 and WALK1, the leaf is
// checked in LEAF, and only then is the next transaction taken. A walk that
// faults at an upper level ends early.
// The result register parts the two channels: a new transaction is taken
// while the previous result is still offered, provided that result is taken
// in the same cycle or the register is empty. While the receiver stalls the
// result holds and the input stalls. Reset clears the walk state, the result
// valid and the configuration. The table memory is not cleared; software must
// load every entry before it is read, which the walker does not enforce.
module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int unsigned TABLE_PAGES   = TABLE_PAGES_DEF,
  parameter int unsigned VA_LIMIT_BITS = VA_LIMIT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned ADDR_W      = PAGE_W + SLOT_W;
  localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

  logic [PTE_W-1:0] table_mem [STORE_WORDS];
  logic [PTE_W-1:0] rdata_q;

  walk_state_e      state_q, state_d;
  logic [VA_W-1:0]  va_q;
  logic             need_user_q;
  logic [3:0]       root_q;
  logic [PPN_W-1:0] base_q;
  logic             out_valid_q;
  out_item_t        result_q;

  logic              in_fire;
  logic              out_free;
  logic              too_large;
  logic              root_outside;
  logic              ent_v;
  logic              ent_u;
  logic [PPN_W-1:0]  ent_ppn;
  logic [PPN_W-1:0]  ppn_diff;
  logic              ptr_outside;
  logic              walk_fault;
  logic [PAGE_W-1:0] next_page;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              res_load;
  out_item_t         res_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == IDLE) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign too_large    = |in_item_i.vaddr[63:VA_LIMIT_BITS];
  assign root_outside = !(32'(root_q) < TABLE_PAGES);

  assign ent_v       = rdata_q[FLAG_V_BIT];
  assign ent_u       = rdata_q[FLAG_U_BIT];
  assign ent_ppn     = rdata_q[PTE_W-1:FLAGS_W];
  assign ppn_diff    = ent_ppn - base_q;
  assign ptr_outside = (ent_ppn < base_q) || (ppn_diff >= PPN_W'(TABLE_PAGES));
  assign walk_fault  = !ent_v || ptr_outside;
  assign next_page   = ppn_diff[PAGE_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      IDLE: begin
        if (in_fire && (in_item_i.kind == KIND_TRANSLATE) && !too_large &&
            !root_outside) begin
          state_d = WALK2;
        end
      end
      WALK2: begin
        state_d = walk_fault ? IDLE : WALK1;
      end
      WALK1: begin
        state_d = walk_fault ? IDLE : LEAF;
      end
      LEAF: begin
        state_d = IDLE;
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_load  = 1'b0;
    res_d     = '{status: ST_OK, phys_addr: '0, leaf_flags: '0};
    unique case (state_q)
      IDLE: begin
        if (in_fire) begin
          if (in_item_i.kind == KIND_WRITE) begin
            mem_we   = 32'(in_item_i.entry_index) < STORE_WORDS;
            res_load = 1'b1;
          end else if (too_large) begin
            res_load     = 1'b1;
            res_d.status = ST_TOO_LARGE;
          end else if (root_outside) begin
            res_load     = 1'b1;
            res_d.status = ST_OUTSIDE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = {PAGE_W'(root_q), in_item_i.vaddr[OFFSET_W+2*SLOT_W +: SLOT_W]};
          end
        end
      end
      WALK2, WALK1: begin
        if (!ent_v) begin
          res_load     = 1'b1;
          res_d.status = ST_NOT_MAPPED;
        end else if (ptr_outside) begin
          res_load     = 1'b1;
          res_d.status = ST_OUTSIDE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (state_q == WALK2) ? {next_page, va_q[OFFSET_W+SLOT_W +: SLOT_W]}
                                         : {next_page, va_q[OFFSET_W +: SLOT_W]};
        end
      end
      LEAF: begin
        res_load = 1'b1;
        if (!ent_v) begin
          res_d.status = ST_NOT_MAPPED;
        end else if (need_user_q && !ent_u) begin
          res_d.status = ST_NOT_USER;
        end else begin
          res_d.phys_addr  = {ent_ppn, va_q[OFFSET_W-1:0]};
          res_d.leaf_flags = rdata_q[FLAGS_W-1:0];
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[ADDR_W'(in_item_i.entry_index)] <= in_item_i.entry_value;
    end
    if (mem_re) begin
      rdata_q <= table_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      base_q      <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROOT_TABLE_PAGE: root_q <= cfg_wdata_i[3:0];
          CFG_STORE_BASE_PPN:  base_q <= cfg_wdata_i[PPN_W-1:0];
          default:             root_q <= root_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      va_q        <= in_item_i.vaddr[VA_W-1:0];
      need_user_q <= in_item_i.require_user;
    end
    if (res_load) begin
      result_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = result_q;

  a_walk_output_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != IDLE) |-> !out_valid_q)
    else $error("result register occupied during a walk");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WALK1) |-> ($past(state_q) == WALK2))
    else $error("level one reached without level two");

  a_leaf_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == LEAF) |-> ($past(state_q) == WALK1))
    else $error("leaf reached without level one");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == IDLE) && !mem_re))
    else $error("table write outside idle state");

  a_ok_flags_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.leaf_flags != '0)) |->
      (result_q.leaf_flags[FLAG_V_BIT] && (result_q.status == ST_OK)))
    else $error("leaf flags reported without a valid leaf");

endmodule
